// ===== rtl/text_console_writer_macros.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_macros
// assertion macros for the console writer rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TCW_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, command types and tables for the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = ROWS * COLUMNS;

	// field widths
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int CHR_W  = 8;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SWL_W  = $clog2(CELLS + 1);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_HOME = ROW_W'(1);

	// cell index split by reciprocal multiply: exact for every index of IDX_W bits
	localparam int DIV_SH  = IDX_W + $clog2(COLUMNS);
	localparam int RECIP   = (2 ** DIV_SH + COLUMNS - 1) / COLUMNS;
	localparam int RECIP_W = $clog2(RECIP + 1);

	// character codes
	localparam logic [CHR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHR_W-1:0] CH_LAST  = 8'hFF;

	localparam logic [CHR_W-1:0]  ATTR_RESET  = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_PUT,
		REQ_CLEAR,
		REQ_SETCUR,
		REQ_READ
	} req_type_t;

	typedef enum logic [3:0] {
		CMD_PRINT,
		CMD_BS,
		CMD_TAB,
		CMD_CR,
		CMD_LF,
		CMD_NOP,
		CMD_CLEAR,
		CMD_SETCUR,
		CMD_READ,
		CMD_RDZERO
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [CHR_W-1:0] chr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_FETCH,
		BK_ADDR,
		BK_EXEC,
		BK_RDATA,
		BK_SWEEP,
		BK_RESULT
	} back_state_t;

	// next tab stop for every column code
	typedef logic [COL_W:0] tab_tbl_t [2 ** COL_W];

	function automatic tab_tbl_t build_tab_stops();
		tab_tbl_t t;
		for (int i = 0; i < 2 ** COL_W; i++) begin
			t[i] = (COL_W + 1)'((i / TAB_WIDTH + 1) * TAB_WIDTH);
		end
		return t;
	endfunction

	localparam tab_tbl_t TAB_STOP = build_tab_stops();

endpackage

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// two-stage intake: splits the read index, saturates cursor targets and
// turns each item into a command for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hold,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [CHR_W-1:0]  char_code,
	input  wire logic [ROW_W-1:0]  row_in,
	input  wire logic [COL_W-1:0]  col_in,
	input  wire logic [IDX_W-1:0]  cell_index,
	output logic                   push,
	output cmd_t                   push_cmd,
	input  wire logic              full
);

	logic v_s1, v_s2;
	logic adv1, adv2, accept, move12;

	req_type_t        req_s1, req_s2;
	logic [CHR_W-1:0] char_s1, char_s2;
	logic [ROW_W-1:0] row_s1, row_s2;
	logic [COL_W-1:0] col_s1, col_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [ROW_W-1:0] quo_s2;
	logic             ok_s2;

	logic [IDX_W+RECIP_W-1:0] prod;
	logic [IDX_W-1:0]         rd_base;

	assign adv2     = !v_s2 || !full;
	assign adv1     = !v_s1 || adv2;
	assign move12   = v_s1 && adv2;
	assign in_stall = !adv1 || hold;
	assign accept   = in_valid && !in_stall;
	assign push     = v_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (move12) begin
				v_s1 <= 1'b0;
			end
			if (move12) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// row = index / COLUMNS
	assign prod = (IDX_W + RECIP_W)'(idx_s1) * (IDX_W + RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type_t'(req_type);
			char_s1 <= char_code;
			row_s1  <= row_in;
			col_s1  <= col_in;
			idx_s1  <= cell_index;
		end
		if (move12) begin
			req_s2  <= req_s1;
			char_s2 <= char_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			idx_s2  <= idx_s1;
			quo_s2  <= ROW_W'(prod >> DIV_SH);
			ok_s2   <= idx_s1 < IDX_W'(CELLS);
		end
	end

	assign rd_base = IDX_W'(quo_s2 * COLUMNS);

	always_comb begin
		push_cmd.kind = CMD_NOP;
		push_cmd.chr  = char_s2;
		push_cmd.row  = (row_s2 > ROW_LAST) ? ROW_LAST : row_s2;
		push_cmd.col  = (col_s2 > COL_LAST) ? COL_LAST : col_s2;
		case (req_s2)
			REQ_PUT: begin
				case (char_s2) inside
					CH_BS:              push_cmd.kind = CMD_BS;
					CH_TAB:             push_cmd.kind = CMD_TAB;
					CH_CR:              push_cmd.kind = CMD_CR;
					CH_LF:              push_cmd.kind = CMD_LF;
					[CH_SPACE:CH_LAST]: push_cmd.kind = CMD_PRINT;
					default:            push_cmd.kind = CMD_NOP;
				endcase
			end
			REQ_CLEAR:  push_cmd.kind = CMD_CLEAR;
			REQ_SETCUR: push_cmd.kind = CMD_SETCUR;
			REQ_READ: begin
				push_cmd.kind = ok_s2 ? CMD_READ : CMD_RDZERO;
				push_cmd.row  = quo_s2;
				push_cmd.col  = COL_W'(idx_s2 - rd_base);
			end
			default: push_cmd.kind = CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// executes commands: cursor state, scroll offset, cell memory and its
// blanking sweeps, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CHR_W-1:0]  attr,
	input  wire logic              q_empty,
	input  wire cmd_t              head,
	output logic                   pop,
	output logic                   init_busy,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic [IDX_W-1:0]       cursor_index,
	output logic [CELL_W-1:0]      cell_data
);

	back_state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q, row_d, first_q, first_d, prow_q, prow_d;
	logic [COL_W-1:0]  col_q, col_d;
	cmd_t              cmd_q, cmd_d;
	logic [ADDR_W-1:0] addr_q, addr_d, base_q, base_d;
	logic [ADDR_W-1:0] swp_addr_q, swp_addr_d;
	logic [SWL_W-1:0]  swp_left_q, swp_left_d;
	logic [CELL_W-1:0] swp_data_q, swp_data_d;
	logic              init_q, init_d;
	logic [CELL_W-1:0] rd_data_q, data_q, data_d;

	logic              out_valid_q, out_valid_d;
	logic [ROW_W-1:0]  out_row_q, out_row_d;
	logic [COL_W-1:0]  out_col_q, out_col_d;
	logic [IDX_W-1:0]  out_idx_q, out_idx_d;
	logic [CELL_W-1:0] out_data_q, out_data_d;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;

	logic              is_move, force_wrap;
	logic [COL_W:0]    col_step;
	logic [ROW_W-1:0]  row_src;
	logic [ROW_W:0]    psum;
	logic [COL_W-1:0]  col_src;

	logic [CELL_W-1:0] mem [CELLS];

	assign init_busy    = init_q;
	assign out_valid    = out_valid_q;
	assign cursor_row   = out_row_q;
	assign cursor_col   = out_col_q;
	assign cursor_index = out_idx_q;
	assign cell_data    = out_data_q;

	assign row_src = (head.kind == CMD_READ) ? head.row : row_q;
	assign psum    = {1'b0, row_src} + {1'b0, first_q};
	assign col_src = (cmd_q.kind == CMD_READ) ? cmd_q.col : col_q;

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		first_d     = first_q;
		prow_d      = prow_q;
		cmd_d       = cmd_q;
		addr_d      = addr_q;
		base_d      = base_q;
		swp_addr_d  = swp_addr_q;
		swp_left_d  = swp_left_q;
		swp_data_d  = swp_data_q;
		init_d      = init_q;
		data_d      = data_q;
		out_valid_d = out_valid_q && out_stall;
		out_row_d   = out_row_q;
		out_col_d   = out_col_q;
		out_idx_d   = out_idx_q;
		out_data_d  = out_data_q;
		pop         = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = swp_addr_q;
		mem_wdata   = swp_data_q;
		is_move     = 1'b0;
		force_wrap  = 1'b0;
		col_step    = {1'b0, col_q};

		case (state_q)
			BK_FETCH: begin
				if (!q_empty && (!out_valid_q || !out_stall)) begin
					pop     = 1'b1;
					cmd_d   = head;
					data_d  = '0;
					prow_d  = (psum >= (ROW_W + 1)'(ROWS)) ?
						ROW_W'(psum - (ROW_W + 1)'(ROWS)) : ROW_W'(psum);
					state_d = BK_ADDR;
				end
			end
			BK_ADDR: begin
				addr_d  = ADDR_W'(prow_q * COLUMNS + col_src);
				base_d  = ADDR_W'(first_q * COLUMNS);
				state_d = BK_EXEC;
			end
			BK_EXEC: begin
				state_d = BK_RESULT;
				case (cmd_q.kind)
					CMD_PRINT: begin
						mem_we    = 1'b1;
						mem_waddr = addr_q;
						mem_wdata = {attr, cmd_q.chr};
						col_step  = {1'b0, col_q} + 1'b1;
						is_move   = 1'b1;
					end
					CMD_BS: begin
						col_d = (col_q == '0) ? col_q : col_q - 1'b1;
					end
					CMD_TAB: begin
						col_step = TAB_STOP[col_q];
						is_move  = 1'b1;
					end
					CMD_CR: begin
						col_d = '0;
					end
					CMD_LF: begin
						is_move    = 1'b1;
						force_wrap = 1'b1;
					end
					CMD_CLEAR: begin
						swp_addr_d = '0;
						swp_left_d = SWL_W'(CELLS);
						swp_data_d = {attr, CH_SPACE};
						first_d    = '0;
						row_d      = ROW_HOME;
						col_d      = '0;
						state_d    = BK_SWEEP;
					end
					CMD_SETCUR: begin
						row_d = cmd_q.row;
						col_d = cmd_q.col;
					end
					CMD_READ: begin
						mem_re  = 1'b1;
						state_d = BK_RDATA;
					end
					default: begin
						state_d = BK_RESULT;
					end
				endcase

				// line wrap and scroll
				if (is_move) begin
					if (force_wrap || col_step >= (COL_W + 1)'(COLUMNS)) begin
						col_d = '0;
						if (row_q == ROW_LAST) begin
							swp_addr_d = base_q;
							swp_left_d = SWL_W'(COLUMNS);
							swp_data_d = {attr, CH_SPACE};
							first_d    = (first_q == ROW_LAST) ? '0 : first_q + 1'b1;
							state_d    = BK_SWEEP;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_step[COL_W-1:0];
					end
				end
			end
			BK_RDATA: begin
				data_d  = rd_data_q;
				state_d = BK_RESULT;
			end
			BK_SWEEP: begin
				mem_we     = 1'b1;
				swp_addr_d = swp_addr_q + 1'b1;
				swp_left_d = swp_left_q - 1'b1;
				if (swp_left_q == SWL_W'(1)) begin
					init_d  = 1'b0;
					state_d = init_q ? BK_FETCH : BK_RESULT;
				end
			end
			BK_RESULT: begin
				out_valid_d = 1'b1;
				out_row_d   = row_q;
				out_col_d   = col_q;
				out_idx_d   = IDX_W'(row_q * COLUMNS + col_q);
				out_data_d  = data_q;
				state_d     = BK_FETCH;
			end
			default: begin
				state_d = BK_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= ROW_HOME;
			col_q       <= '0;
			first_q     <= '0;
			init_q      <= 1'b1;
			swp_addr_q  <= '0;
			swp_left_q  <= SWL_W'(CELLS);
			swp_data_q  <= RESET_BLANK;
			out_valid_q <= 1'b0;
		end else begin
			row_q       <= row_d;
			col_q       <= col_d;
			first_q     <= first_d;
			init_q      <= init_d;
			swp_addr_q  <= swp_addr_d;
			swp_left_q  <= swp_left_d;
			swp_data_q  <= swp_data_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		prow_q     <= prow_d;
		cmd_q      <= cmd_d;
		addr_q     <= addr_d;
		base_q     <= base_d;
		data_q     <= data_d;
		out_row_q  <= out_row_d;
		out_col_q  <= out_col_d;
		out_idx_q  <= out_idx_d;
		out_data_q <= out_data_d;
	end

	// cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[addr_q];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: put character, clear, set cursor and read cell, each
// answered with the cursor position and the crtc cursor index
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  config  | cfg_wr_en                 | cfg_wr_data (text attribute)
//  request | in_valid / in_stall       | req_type, char_code, row_in, col_in,
//          |                           | cell_index
//  result  | out_valid / out_stall     | cursor_row, cursor_col, cursor_index,
//          |                           | cell_data
//
//  an item passes the front stages, then the back end states fetch, address,
//  execute and result; a read adds a state for the memory data. a line feed
//  or wrap on the bottom row adds a sweep that blanks a row and a clear one
//  over every cell; the single write port of the cell memory sets both.
//  after reset a pass blanks the memory with in_stall held high.
//  a two-entry queue lets the front keep taking items while the back is busy
//  or out_stall holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CHR_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [CHR_W-1:0]  char_code,
	input  wire logic [ROW_W-1:0]  row_in,
	input  wire logic [COL_W-1:0]  col_in,
	input  wire logic [IDX_W-1:0]  cell_index,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic [IDX_W-1:0]       cursor_index,
	output logic [CELL_W-1:0]      cell_data
);

	// text attribute: background high nibble, foreground low nibble
	logic [CHR_W-1:0] text_attribute_q;

	// front to queue
	logic q_push, q_full;
	cmd_t q_push_cmd;

	// queue to back
	logic q_pop, q_empty;
	cmd_t q_head;

	// memory clearing pass in progress
	logic init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			text_attribute_q <= cfg_wr_data;
		end
	end

	// intake: classify each item, split the read index, saturate targets
	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (init_busy),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.row_in     (row_in),
		.col_in     (col_in),
		.cell_index (cell_index),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full)
	);

	// decouples intake from the slow sweeps in the back end
	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// cursor, scroll offset, cell memory and result register
	tcw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.attr         (text_attribute_q),
		.q_empty      (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.cursor_index (cursor_index),
		.cell_data    (cell_data)
	);

	// reported cursor index agrees with the reported row and column
	`TCW_ASSERT_IMP(a_index_match, out_valid, cursor_index == IDX_W'(cursor_row * COLUMNS + cursor_col), "cursor index does not match row and column")

	// reported cursor stays on screen
	`TCW_ASSERT_IMP(a_cursor_bounds, out_valid, (cursor_row <= ROW_LAST) && (cursor_col <= COL_LAST), "cursor off screen")

	// no intake and no result during the clearing pass
	`TCW_ASSERT_IMP(a_init_quiet, init_busy, in_stall && !out_valid, "activity during memory clearing pass")

	// front never pushes into a full queue
	`TCW_ASSERT(a_no_overflow, !(q_push && q_full), "push into full command queue")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text console writer: a table of directed console
// requests, then random put, clear, cursor and read traffic under several text
// attributes, with every result compared against a hand-typed value or a
// behavioral screen model

module tb_top;
	import tcw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;	// a clear sweep plus long stalls fits many times over
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 275;
	localparam int DIRECTED_COUNT = 25;
	localparam int SETTLE_CYCLES  = 10;	// back end latency with margin before a config write
	localparam int TAIL_CYCLES    = 50;

	// one result item as the console reports it
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [IDX_W-1:0]  index;
		logic [CELL_W-1:0] data;
	} cursor_report_t;

	// one request item
	typedef struct packed {
		req_type_t        req;
		logic [CHR_W-1:0] chr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [IDX_W-1:0] idx;
	} console_req_t;

	// directed row: pinned rows carry a hand-typed result, the rest use the model
	typedef struct packed {
		console_req_t   item;
		logic           pinned;
		cursor_report_t want;
	} directed_step_t;

	// receiver stall styles
	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_LIGHT,
		DRAIN_HEAVY,
		DRAIN_RUNS
	} drain_mode_t;

	// dut signals, every input known from time zero
	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [CHR_W-1:0]    cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [1:0]          req_type    = '0;
	logic [CHR_W-1:0]    char_code   = '0;
	logic [ROW_W-1:0]    row_in      = '0;
	logic [COL_W-1:0]    col_in      = '0;
	logic [IDX_W-1:0]    cell_index  = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [ROW_W-1:0]    cursor_row;
	logic [COL_W-1:0]    cursor_col;
	logic [IDX_W-1:0]    cursor_index;
	logic [CELL_W-1:0]   cell_data;

	// screen model state
	logic [CELL_W-1:0] shadow_cells [CELLS];
	int                cur_row;
	int                cur_col;
	int                top_slot;	// physical row holding logical row 0
	logic [CHR_W-1:0]  shadow_attr;

	// results still owed by the dut, oldest first
	cursor_report_t pending_reports [$];

	// bookkeeping
	int report_errors   = 0;
	int results_checked = 0;
	int scroll_count    = 0;
	int attr_writes     = 0;
	int req_seen [4]    = '{0, 0, 0, 0};
	int idle_cycles     = 0;

	text_console_writer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.char_code    (char_code),
		.row_in       (row_in),
		.col_in       (col_in),
		.cell_index   (cell_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.cursor_index (cursor_index),
		.cell_data    (cell_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// directed table: reset contents, out-of-range reads, backspace at column
	// zero, tab, ignored control codes, the top printable code, cursor
	// saturation, wrap and scroll from the bottom-right corner, tab and line
	// feed on the bottom row, and clear
	// ------------------------------------------------------------------------
	directed_step_t directed_steps [DIRECTED_COUNT] = '{
		// reset screen and cursor, then reads past the last cell
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd0},    1'b1, '{5'd1, 7'd0, 11'd80, RESET_BLANK}},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd1999}, 1'b1, '{5'd1, 7'd0, 11'd80, RESET_BLANK}},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd2047}, 1'b1, '{5'd1, 7'd0, 11'd80, 16'h0000}},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd2000}, 1'b1, '{5'd1, 7'd0, 11'd80, 16'h0000}},
		// print, step back, then backspace that cannot move
		'{'{REQ_PUT,    8'h41,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_BS,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_BS,    5'd0,  7'd0,   11'd0},    1'b1, '{5'd1, 7'd0, 11'd80, 16'h0000}},
		'{'{REQ_PUT,    CH_TAB,   5'd0,  7'd0,   11'd0},    1'b0, '0},
		// control codes that change nothing, the top printable code, a return, a read
		'{'{REQ_PUT,    8'h00,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    8'h1F,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_LAST,  5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_CR,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd80},   1'b0, '0},
		// cursor saturates, then a print in the corner wraps and scrolls
		'{'{REQ_SETCUR, 8'h00,    5'd31, 7'd127, 11'd0},    1'b1, '{5'd24, 7'd79, 11'd1999, 16'h0000}},
		'{'{REQ_PUT,    8'h7E,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd1919}, 1'b0, '0},
		'{'{REQ_SETCUR, 8'h00,    5'd0,  7'd0,   11'd0},    1'b1, '{5'd0, 7'd0, 11'd0, 16'h0000}},
		// tab past the last stop and line feed, both on the bottom row
		'{'{REQ_SETCUR, 8'h00,    5'd24, 7'd76,  11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_TAB,   5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_LF,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd0},    1'b0, '0},
		// clear brings back the home position and blank cells
		'{'{REQ_CLEAR,  8'h00,    5'd0,  7'd0,   11'd0},    1'b1, '{5'd1, 7'd0, 11'd80, 16'h0000}},
		'{'{REQ_READ,   8'h00,    5'd0,  7'd0,   11'd80},   1'b1, '{5'd1, 7'd0, 11'd80, RESET_BLANK}},
		'{'{REQ_SETCUR, 8'h00,    5'd5,  7'd3,   11'd0},    1'b0, '0},
		'{'{REQ_PUT,    CH_SPACE, 5'd0,  7'd0,   11'd0},    1'b0, '0}
	};

	// ------------------------------------------------------------------------
	// screen model
	// ------------------------------------------------------------------------
	function automatic void blank_line(int prow);
		for (int c = 0; c < COLUMNS; c++) begin
			shadow_cells[prow * COLUMNS + c] = {shadow_attr, CH_SPACE};
		end
	endfunction

	// column zero of the next row; past the bottom the oldest row is recycled
	function automatic void new_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			blank_line(top_slot);
			top_slot = (top_slot + 1) % ROWS;
			cur_row  = ROWS - 1;
			scroll_count++;
		end
	endfunction

	function automatic void put_code(logic [CHR_W-1:0] c);
		if (c == CH_BS) begin
			if (cur_col != 0) cur_col--;
		end else if (c == CH_TAB) begin
			cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
		end else if (c == CH_CR) begin
			cur_col = 0;
		end else if (c == CH_LF) begin
			new_line();
		end else if (c >= CH_SPACE) begin
			shadow_cells[((cur_row + top_slot) % ROWS) * COLUMNS + cur_col] = {shadow_attr, c};
			cur_col++;
		end
		if (cur_col >= COLUMNS) new_line();
	endfunction

	// applies one accepted request to the model and returns its result
	function automatic cursor_report_t apply_request(console_req_t r);
		cursor_report_t   rep;
		logic [CELL_W-1:0] word;
		int               lrow;
		int               lcol;
		word = '0;
		case (r.req)
			REQ_PUT: begin
				put_code(r.chr);
			end
			REQ_CLEAR: begin
				for (int p = 0; p < ROWS; p++) blank_line(p);
				top_slot = 0;
				cur_col  = 0;
				cur_row  = ROW_HOME;
			end
			REQ_SETCUR: begin
				cur_row = (r.row > ROW_LAST) ? ROW_LAST : r.row;
				cur_col = (r.col > COL_LAST) ? COL_LAST : r.col;
			end
			default: begin
				if (r.idx < CELLS) begin
					lrow = r.idx / COLUMNS;
					lcol = r.idx % COLUMNS;
					word = shadow_cells[((lrow + top_slot) % ROWS) * COLUMNS + lcol];
				end
			end
		endcase
		rep.row   = ROW_W'(cur_row);
		rep.col   = COL_W'(cur_col);
		rep.index = IDX_W'(cur_row * COLUMNS + cur_col);
		rep.data  = word;
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// random traffic: printing with line control, many reads (near the
	// cursor to see fresh writes, anywhere, and past the end), cursor moves
	// biased to the bottom-right corner so wraps and scrolls come often, and
	// rare clears since each one sweeps the whole screen
	// ------------------------------------------------------------------------
	function automatic console_req_t random_request();
		console_req_t r;
		int           pick;
		int           sub;
		int           here;
		// unused fields still get random values
		r.req = REQ_PUT;
		r.chr = CHR_W'($urandom);
		r.row = ROW_W'($urandom);
		r.col = COL_W'($urandom);
		r.idx = IDX_W'($urandom);
		pick  = $urandom_range(0, 199);
		sub   = $urandom_range(0, 99);
		if (pick < 90) begin
			if (sub < 65)      r.chr = CHR_W'($urandom_range(CH_SPACE, CH_LAST));
			else if (sub < 73) r.chr = CH_LF;
			else if (sub < 81) r.chr = CH_BS;
			else if (sub < 87) r.chr = CH_TAB;
			else if (sub < 92) r.chr = CH_CR;
			else               r.chr = CHR_W'($urandom_range(0, CH_SPACE - 1));
		end else if (pick < 100) begin
			r.req = REQ_SETCUR;
			if (sub < 50) begin
				r.row = ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
				r.col = COL_W'($urandom_range(COLUMNS - 10, COLUMNS - 1));
			end
		end else if (pick < 198) begin
			r.req = REQ_READ;
			if (sub < 40) begin
				// the cell just behind the cursor, usually the last one printed
				here  = cur_row * COLUMNS + cur_col;
				r.idx = IDX_W'((here == 0) ? 0 : here - 1);
			end else if (sub < 80) begin
				r.idx = IDX_W'($urandom_range(0, CELLS - 1));
			end else begin
				r.idx = IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
			end
		end else begin
			r.req = REQ_CLEAR;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// sender: called at a falling edge, holds the item until it is taken,
	// predicts its result and returns at the next falling edge
	// ------------------------------------------------------------------------
	task automatic send_request(console_req_t r, logic pinned, cursor_report_t want);
		cursor_report_t predicted;
		req_type   <= r.req;
		char_code  <= r.chr;
		row_in     <= r.row;
		col_in     <= r.col;
		cell_index <= r.idx;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// the model always runs so its state follows the dut
		predicted = apply_request(r);
		pending_reports.push_back(pinned ? want : predicted);
		req_seen[int'(r.req)]++;
		@(negedge clk);
	endtask

	// wait until every result is back and the back end has settled, then
	// write the attribute register
	task automatic write_attribute(logic [CHR_W-1:0] attr);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= attr;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_attr = attr;
		attr_writes++;
	endtask

	// ------------------------------------------------------------------------
	// receiver: switches between random stall styles so stalls land on every
	// stage of the back end, with free-running stretches
	// ------------------------------------------------------------------------
	drain_mode_t drain_mode = DRAIN_FREE;
	int          drain_left = 0;
	int          stall_run  = 0;

	always @(negedge clk) begin
		if (drain_left == 0) begin
			drain_mode = drain_mode_t'($urandom_range(0, 3));
			drain_left = $urandom_range(32, 256);
		end else begin
			drain_left--;
		end
		case (drain_mode)
			DRAIN_FREE:  out_stall <= 1'b0;
			DRAIN_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
			DRAIN_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
			default: begin
				// long runs of stall and flow
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run = $urandom_range(1, 20);
				end else begin
					stall_run--;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// result checker: every taken result against the oldest expectation
	// ------------------------------------------------------------------------
	task automatic check_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			report_errors++;
		end
	endtask

	always @(posedge clk) begin
		cursor_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d index %0d data 0x%0h",
					$time, cursor_row, cursor_col, cursor_index, cell_data);
				report_errors++;
			end else begin
				want = pending_reports.pop_front();
				results_checked++;
				check_field("cursor_row", CELL_W'(want.row), CELL_W'(cursor_row));
				check_field("cursor_col", CELL_W'(want.col), CELL_W'(cursor_col));
				check_field("cursor_index", CELL_W'(want.index), CELL_W'(cursor_index));
				check_field("cell_data", want.data, cell_data);
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long with no item moving on either channel ends the run
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("text_console_writer regression: fail");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		console_req_t     r;
		logic [CHR_W-1:0] attr;
		int               burst_left;
		int               gap;

		// model starts from the reset screen
		shadow_attr = ATTR_RESET;
		for (int p = 0; p < ROWS; p++) blank_line(p);
		cur_row  = ROW_HOME;
		cur_col  = 0;
		top_slot = 0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// the dut blanks its memory after reset with the input stalled
		@(negedge clk);
		while (in_stall) @(negedge clk);

		// directed table under the reset attribute, no idling
		for (int n = 0; n < DIRECTED_COUNT; n++) begin
			send_request(directed_steps[n].item, directed_steps[n].pinned, directed_steps[n].want);
		end

		// random phases, each under its own attribute; the drain before each
		// write is also the sender's full pause
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       attr = 8'h00;
				1:       attr = 8'hFF;
				2:       attr = ATTR_RESET;
				default: attr = CHR_W'($urandom_range(0, 255));
			endcase
			write_attribute(attr);

			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					// bursts of random length, now and then a long one
					burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
					gap = $urandom_range(0, 12);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
				r = random_request();
				send_request(r, 1'b0, '0);
				burst_left--;
			end
		end

		// let the last results come back, then watch for strays
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("requests taken: %0d put, %0d clear, %0d set cursor, %0d read; %0d scrolls",
			req_seen[int'(REQ_PUT)], req_seen[int'(REQ_CLEAR)],
			req_seen[int'(REQ_SETCUR)], req_seen[int'(REQ_READ)], scroll_count);
		$display("%0d results checked over %0d attribute settings, %0d mismatches",
			results_checked, attr_writes, report_errors);
		if (report_errors == 0) begin
			$display("text_console_writer regression: pass");
		end else begin
			$display("text_console_writer regression: fail");
		end
		$finish;
	end

endmodule
